FILE: hw/rtl/psa_pkg.sv
// ----------------------------------------------------------------------------
// Pool slot allocator package
// Shared types, request and response codes, and controller/datapath links.
// ----------------------------------------------------------------------------
package psa_pkg;

   localparam int POOL_SLOTS = 256;
   localparam int SLOT_W     = 9;
   localparam int IDX_W      = 8;

   localparam logic [SLOT_W-1:0] NIL_SLOT = SLOT_W'(POOL_SLOTS);

   typedef enum logic [1:0] {
      KIND_ALLOC = 2'd0,
      KIND_FREE  = 2'd1,
      KIND_NEXT  = 2'd2,
      KIND_NONE  = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_BAD   = 2'd2,
      ST_RSVD  = 2'd3
   } status_type;

   typedef struct packed {
      logic [1:0]        kind;
      logic [SLOT_W-1:0] slot;
   } req_type;

   typedef struct packed {
      logic [SLOT_W-1:0] result_slot;
      logic [1:0]        status;
      logic [SLOT_W-1:0] used_count;
   } rsp_type;

   typedef struct packed {
      logic              in_use;
      logic [SLOT_W-1:0] next;
   } node_type;

   typedef enum logic [2:0] {
      RSP_NIL_OK,
      RSP_EMPTY,
      RSP_BAD,
      RSP_GRANT,
      RSP_NEXT,
      RSP_HEAD
   } rsp_sel_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_ISSUE,
      S_EVAL,
      S_LINK
   } state_type;

   typedef struct packed {
      logic        req_load;
      logic        rd_en;
      logic        alloc_commit;
      logic        alloc_link;
      logic        free_commit;
      logic        free_link;
      logic        rsp_load;
      rsp_sel_type rsp_sel;
   } ctl_cmd_type;

   typedef struct packed {
      kind_type kind;
      logic     pool_empty;
      logic     slot_nil;
      logic     slot_oob;
      logic     rd_in_use;
   } ctl_status_type;

endpackage

FILE: hw/rtl/psa_ctrl.sv
// ----------------------------------------------------------------------------
// Pool slot allocator controller
// Sequences each request through issue and, where needed, evaluate and link steps.
// ----------------------------------------------------------------------------
module psa_ctrl
   import psa_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   output logic           busy,
   input  ctl_status_type status,
   output ctl_cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.rsp_sel = RSP_NIL_OK;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.req_load = 1'b1;
               state_in     = S_ISSUE;
            end
         end
         S_ISSUE: begin
            state_in = S_IDLE;
            case (status.kind)
               KIND_ALLOC: begin
                  if (status.pool_empty) begin
                     cmd.rsp_load = 1'b1;
                     cmd.rsp_sel  = RSP_EMPTY;
                  end else begin
                     cmd.rd_en = 1'b1;
                     state_in  = S_EVAL;
                  end
               end
               KIND_FREE: begin
                  if (status.slot_nil || status.slot_oob) begin
                     cmd.rsp_load = 1'b1;
                     cmd.rsp_sel  = RSP_BAD;
                  end else begin
                     cmd.rd_en = 1'b1;
                     state_in  = S_EVAL;
                  end
               end
               KIND_NEXT: begin
                  if (status.slot_nil) begin
                     cmd.rsp_load = 1'b1;
                     cmd.rsp_sel  = RSP_HEAD;
                  end else if (status.slot_oob) begin
                     cmd.rsp_load = 1'b1;
                     cmd.rsp_sel  = RSP_BAD;
                  end else begin
                     cmd.rd_en = 1'b1;
                     state_in  = S_EVAL;
                  end
               end
               default: begin
                  cmd.rsp_load = 1'b1;
                  cmd.rsp_sel  = RSP_NIL_OK;
               end
            endcase
         end
         S_EVAL: begin
            state_in = S_IDLE;
            case (status.kind)
               KIND_ALLOC: begin
                  cmd.alloc_commit = 1'b1;
                  state_in         = S_LINK;
               end
               KIND_FREE: begin
                  if (!status.rd_in_use) begin
                     cmd.rsp_load = 1'b1;
                     cmd.rsp_sel  = RSP_BAD;
                  end else begin
                     cmd.free_commit = 1'b1;
                     state_in        = S_LINK;
                  end
               end
               default: begin
                  cmd.rsp_load = 1'b1;
                  cmd.rsp_sel  = status.rd_in_use ? RSP_NEXT : RSP_BAD;
               end
            endcase
         end
         S_LINK: begin
            state_in     = S_IDLE;
            cmd.rsp_load = 1'b1;
            if (status.kind == KIND_ALLOC) begin
               cmd.alloc_link = 1'b1;
               cmd.rsp_sel    = RSP_GRANT;
            end else begin
               cmd.free_link = 1'b1;
               cmd.rsp_sel   = RSP_NIL_OK;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

FILE: hw/rtl/psa_dp.sv
// ----------------------------------------------------------------------------
// Pool slot allocator datapath
// Link memories, list heads, used count and the response register.
// ----------------------------------------------------------------------------
module psa_dp
   import psa_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  req_type        req_data,
   input  ctl_cmd_type    cmd,
   output ctl_status_type status,
   output logic           rsp_valid,
   output rsp_type        rsp_data
);

   node_type          node_mem [POOL_SLOTS];
   logic [SLOT_W-1:0] prev_mem [POOL_SLOTS];
   logic [POOL_SLOTS-1:0] written_ff;

   req_type           req_ff;
   logic [SLOT_W-1:0] free_head_ff;
   logic [SLOT_W-1:0] used_head_ff;
   logic [SLOT_W-1:0] count_ff;
   logic [IDX_W-1:0]  rd_idx_ff;
   logic              rd_written_ff;
   node_type          node_q_ff;
   logic [SLOT_W-1:0] prev_q_ff;
   logic [SLOT_W-1:0] lnk_p_ff;
   logic [SLOT_W-1:0] lnk_n_ff;
   logic              rsp_valid_ff;
   rsp_type           rsp_ff;

   logic [IDX_W-1:0]  rd_addr;
   node_type          node_rd;
   logic [SLOT_W-1:0] cur_slot;
   logic              node_we;
   logic [IDX_W-1:0]  node_waddr;
   node_type          node_wdata;
   logic              prev_we;
   logic [IDX_W-1:0]  prev_waddr;
   logic [SLOT_W-1:0] prev_wdata;
   rsp_type           rsp_in;

   assign cur_slot = {1'b0, rd_idx_ff};
   assign rd_addr  = (req_ff.kind == KIND_ALLOC) ? free_head_ff[IDX_W-1:0]
                                                : req_ff.slot[IDX_W-1:0];

   always_comb begin
      if (rd_written_ff) begin
         node_rd = node_q_ff;
      end else begin
         node_rd.in_use = 1'b0;
         node_rd.next   = cur_slot + SLOT_W'(1);
      end
   end

   assign status.kind       = kind_type'(req_ff.kind);
   assign status.pool_empty = free_head_ff[IDX_W];
   assign status.slot_nil   = (req_ff.slot == NIL_SLOT);
   assign status.slot_oob   = req_ff.slot[IDX_W] && (req_ff.slot != NIL_SLOT);
   assign status.rd_in_use  = node_rd.in_use;

   always_comb begin
      node_we         = 1'b0;
      node_waddr      = rd_idx_ff;
      node_wdata      = node_rd;
      prev_we         = 1'b0;
      prev_waddr      = rd_idx_ff;
      prev_wdata      = NIL_SLOT;
      if (cmd.alloc_commit) begin
         node_we           = 1'b1;
         node_wdata.in_use = 1'b1;
         node_wdata.next   = used_head_ff;
         prev_we           = 1'b1;
         prev_wdata        = NIL_SLOT;
      end
      if (cmd.alloc_link) begin
         prev_we    = !used_head_ff[IDX_W];
         prev_waddr = used_head_ff[IDX_W-1:0];
         prev_wdata = cur_slot;
      end
      if (cmd.free_commit) begin
         node_we           = 1'b1;
         node_wdata.in_use = 1'b0;
         node_wdata.next   = free_head_ff;
         prev_we           = !node_rd.next[IDX_W];
         prev_waddr        = node_rd.next[IDX_W-1:0];
         prev_wdata        = prev_q_ff;
      end
      if (cmd.free_link) begin
         node_we           = !lnk_p_ff[IDX_W];
         node_waddr        = lnk_p_ff[IDX_W-1:0];
         node_wdata.in_use = 1'b1;
         node_wdata.next   = lnk_n_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (node_we) begin
         node_mem[node_waddr] <= node_wdata;
      end
      if (prev_we) begin
         prev_mem[prev_waddr] <= prev_wdata;
      end
      if (cmd.rd_en) begin
         node_q_ff <= node_mem[rd_addr];
         prev_q_ff <= prev_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.req_load) begin
         req_ff <= req_data;
      end
      if (cmd.rd_en) begin
         rd_idx_ff     <= rd_addr;
         rd_written_ff <= written_ff[rd_addr];
      end
      if (cmd.free_commit) begin
         lnk_p_ff <= prev_q_ff;
         lnk_n_ff <= node_rd.next;
      end
      if (cmd.rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff   <= '0;
         free_head_ff <= '0;
         used_head_ff <= NIL_SLOT;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.rsp_load;
         if (node_we) begin
            written_ff[node_waddr] <= 1'b1;
         end
         if (cmd.alloc_commit) begin
            free_head_ff <= node_rd.next;
            count_ff     <= count_ff + SLOT_W'(1);
         end
         if (cmd.alloc_link) begin
            used_head_ff <= cur_slot;
         end
         if (cmd.free_commit) begin
            free_head_ff <= cur_slot;
            count_ff     <= count_ff - SLOT_W'(1);
            if (prev_q_ff[IDX_W]) begin
               used_head_ff <= node_rd.next;
            end
         end
      end
   end

   always_comb begin
      rsp_in.used_count  = count_ff;
      rsp_in.result_slot = NIL_SLOT;
      rsp_in.status      = ST_OK;
      case (cmd.rsp_sel)
         RSP_EMPTY: begin
            rsp_in.status = ST_EMPTY;
         end
         RSP_BAD: begin
            rsp_in.status = ST_BAD;
         end
         RSP_GRANT: begin
            rsp_in.result_slot = cur_slot;
         end
         RSP_NEXT: begin
            rsp_in.result_slot = node_rd.next;
         end
         RSP_HEAD: begin
            rsp_in.result_slot = used_head_ff;
         end
         default: begin
            rsp_in.result_slot = NIL_SLOT;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

FILE: hw/rtl/pool_slot_allocator_core.sv
// ----------------------------------------------------------------------------
// Pool slot allocator core
// Free list and doubly linked used list over a fixed pool of slots.
//
//   Channel   Ports                    Direction  Handshake
//   request   start, busy, req_data    in         accepted when start and !busy
//   response  rsp_valid, rsp_data      out        one-cycle strobe, no stall
//
// After an allocate or a free is accepted, it steps through issue, evaluate
// and link states before its response strobe is registered; a next query or a
// free of a slot not in use takes issue and evaluate, and an early reject or a
// walk from none takes issue alone. The single-port link memories set this: a
// read, then up to two dependent writes to each memory. Busy falls as the
// response is registered, so a new request can be accepted while the response strobe is shown.
// Reset is synchronous and needs no clearing pass; the receiver cannot stall.
// ----------------------------------------------------------------------------
module pool_slot_allocator_core
   import psa_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   ctl_cmd_type    cmd;
   ctl_status_type status;

   psa_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   psa_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule
